FILE: design/d2p_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel to colored point: shared package
// Widths, codes, configuration and command types used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package d2p_pkg;

  // Default frame limits handed to the top level parameters.
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Field widths.
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned PACKED_W  = 3 * COLOR_W;
  localparam int unsigned COORD_W   = 40;
  localparam int unsigned Z_W       = 34;
  localparam int unsigned PRIN_W    = 16;
  localparam int unsigned INV_W     = 24;
  localparam int unsigned SCALE_W   = 18;
  localparam int unsigned SIZE_W    = 13;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  // Shared multiplier and rounding.
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned RND_SHIFT = 28;
  localparam int unsigned RND_W     = MUL_P_W + 1 - RND_SHIFT;
  localparam int unsigned AHI_W     = 24;
  localparam int unsigned Q_W       = 53;

  localparam logic [COORD_W-1:0] POS_LIMIT = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_LIMIT = {1'b1, {(COORD_W-1){1'b0}}};

  // Reset values of the configuration registers.
  localparam logic [PRIN_W-1:0]  PRINCIPAL_X_RST = 16'd5120;
  localparam logic [PRIN_W-1:0]  PRINCIPAL_Y_RST = 16'd3840;
  localparam logic [INV_W-1:0]   INV_FOCAL_RST   = 24'd31957;
  localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST = 18'd65536;
  localparam logic [SIZE_W-1:0]  WIDTH_RST       = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST      = 13'd480;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_X  = 3'd0,
    REG_PRINCIPAL_Y  = 3'd1,
    REG_INV_FOCAL_X  = 3'd2,
    REG_INV_FOCAL_Y  = 3'd3,
    REG_DEPTH_SCALE  = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6,
    REG_MONO_MODE    = 3'd7
  } cfg_idx_e;

  // Color input format.
  typedef enum logic {
    CMODE_RGB8  = 1'b0,
    CMODE_MONO8 = 1'b1
  } color_mode_e;

  typedef struct packed {
    logic [PRIN_W-1:0]  principal_x;
    logic [PRIN_W-1:0]  principal_y;
    logic [INV_W-1:0]   inv_focal_x;
    logic [INV_W-1:0]   inv_focal_y;
    logic [SCALE_W-1:0] depth_scale;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    color_mode_e        color_mode;
  } cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_Z,
    MUL_MAG_LO,
    MUL_A_LO,
    MUL_A_HI
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    mul_op_e mul_op;
    logic    axis_y;
    logic    rnd_en;
    logic    q_en;
    logic    res_en;
    logic    out_load;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/d2p_pixel_if.sv
// ----------------------------------------------------------------------------
// Depth pixel channel
// One depth sample with its validity flag and its color bytes per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface d2p_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [d2p_pkg::DEPTH_W-1:0]   depth_raw;
  logic                          depth_valid;
  logic [d2p_pkg::COLOR_W-1:0]   red;
  logic [d2p_pkg::COLOR_W-1:0]   green;
  logic [d2p_pkg::COLOR_W-1:0]   blue;

  modport source (output valid, depth_raw, depth_valid, red, green, blue, input ready);
  modport sink   (input valid, depth_raw, depth_valid, red, green, blue, output ready);
endinterface

`default_nettype wire

FILE: design/d2p_point_if.sv
// ----------------------------------------------------------------------------
// Colored point channel
// One back-projected point with its packed color and frame marker per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface d2p_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [d2p_pkg::COORD_W-1:0]  point_x;
  logic signed [d2p_pkg::COORD_W-1:0]  point_y;
  logic [d2p_pkg::Z_W-1:0]             point_z;
  logic                                point_valid;
  logic [d2p_pkg::PACKED_W-1:0]        packed_color;
  logic                                frame_end;

  modport source (output valid, point_x, point_y, point_z, point_valid, packed_color,
                  frame_end, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, packed_color,
                  frame_end, output ready);
endinterface

`default_nettype wire

FILE: design/d2p_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Camera intrinsics, depth scale, frame size and color mode, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module d2p_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [d2p_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [d2p_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output d2p_pkg::cfg_t                         cfg_o
);
  import d2p_pkg::*;

  cfg_t cfg_q;

  // Register file with reset values; one register per write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.principal_x  <= PRINCIPAL_X_RST;
      cfg_q.principal_y  <= PRINCIPAL_Y_RST;
      cfg_q.inv_focal_x  <= INV_FOCAL_RST;
      cfg_q.inv_focal_y  <= INV_FOCAL_RST;
      cfg_q.depth_scale  <= DEPTH_SCALE_RST;
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
      cfg_q.color_mode   <= CMODE_RGB8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_PRINCIPAL_X:  cfg_q.principal_x  <= cfg_wdata_i[PRIN_W-1:0];
        REG_PRINCIPAL_Y:  cfg_q.principal_y  <= cfg_wdata_i[PRIN_W-1:0];
        REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_wdata_i[INV_W-1:0];
        REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_wdata_i[INV_W-1:0];
        REG_DEPTH_SCALE:  cfg_q.depth_scale  <= cfg_wdata_i[SCALE_W-1:0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i[SIZE_W-1:0];
        REG_MONO_MODE:    cfg_q.color_mode   <= color_mode_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/d2p_ctrl.sv
// ----------------------------------------------------------------------------
// Controller
// Sequences the shared multiplier through z, then the x and y projections,
// and hands the finished point to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module d2p_ctrl (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output d2p_pkg::cmd_t  cmd_o
);
  import d2p_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_Z,
    S_ML,
    S_MH,
    S_PH,
    S_RQ,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   axis_q;
  logic   out_valid_q;
  logic   out_free;
  logic   out_load;
  logic   in_fire;

  // The output register is free when empty or when its word leaves now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_OUT) && out_free;
  assign in_ready_o = (state_q == S_IDLE) || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = MUL_NONE;
    cmd_o.load_in  = in_fire;
    cmd_o.axis_y   = axis_q;
    cmd_o.out_load = out_load;
    case (state_q)
      S_Z:  cmd_o.mul_op = MUL_Z;
      S_ML: cmd_o.mul_op = MUL_MAG_LO;
      S_MH: cmd_o.mul_op = MUL_A_LO;
      S_PH: begin
        cmd_o.mul_op = MUL_A_HI;
        cmd_o.rnd_en = 1'b1;
      end
      S_RQ:  cmd_o.q_en   = 1'b1;
      S_FIN: cmd_o.res_en = 1'b1;
      default: ;
    endcase
  end

  // State, axis select and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_Z;
          end
        end
        S_Z: begin
          axis_q  <= 1'b0;
          state_q <= S_ML;
        end
        S_ML: state_q <= S_MH;
        S_MH: state_q <= S_PH;
        S_PH: state_q <= S_RQ;
        S_RQ: state_q <= S_FIN;
        S_FIN: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_ML;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= in_fire ? S_Z : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/d2p_dp.sv
// ----------------------------------------------------------------------------
// Datapath
// Pixel counters, input capture, one shared 32x24 multiplier with its
// operand registers, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module d2p_dp #(
  parameter int unsigned MAX_WIDTH  = d2p_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = d2p_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire d2p_pkg::cfg_t                       cfg_i,
  input  wire d2p_pkg::cmd_t                       cmd_i,
  input  wire logic [d2p_pkg::DEPTH_W-1:0]         depth_raw_i,
  input  wire logic                                depth_valid_i,
  input  wire logic [d2p_pkg::COLOR_W-1:0]         red_i,
  input  wire logic [d2p_pkg::COLOR_W-1:0]         green_i,
  input  wire logic [d2p_pkg::COLOR_W-1:0]         blue_i,
  output logic signed [d2p_pkg::COORD_W-1:0]       point_x_o,
  output logic signed [d2p_pkg::COORD_W-1:0]       point_y_o,
  output logic [d2p_pkg::Z_W-1:0]                  point_z_o,
  output logic                                     point_valid_o,
  output logic [d2p_pkg::PACKED_W-1:0]             packed_color_o,
  output logic                                     frame_end_o
);
  import d2p_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned CMP_W = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;
  localparam int unsigned MAG_W = (POS_W + 4 > PRIN_W) ? POS_W + 4 : PRIN_W;
  localparam int unsigned MZH_W = MAG_W + 2;

  // Pixel position counters.
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             last_col;
  logic             last_row;

  // Captured item.
  logic [POS_W-1:0]    pos_x_q;
  logic [POS_W-1:0]    pos_y_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic                dvalid_q;
  logic [PACKED_W-1:0] color_q;
  logic                fend_q;
  logic [PACKED_W-1:0] color_in;

  // Arithmetic registers.
  logic [Z_W-1:0]     z_q;
  logic [MUL_P_W-1:0] t_q;
  logic [MUL_P_W-1:0] plo_q;
  logic [MUL_P_W-1:0] phi_q;
  logic [AHI_W-1:0]   ahi_q;
  logic [RND_W-1:0]   rnd_q;
  logic [Q_W-1:0]     q_q;
  logic               neg_q;
  logic [COORD_W-1:0] res_x_q;
  logic [COORD_W-1:0] res_y_q;

  logic [POS_W-1:0]   pos_sel;
  logic [PRIN_W-1:0]  prin_sel;
  logic [INV_W-1:0]   inv_sel;
  logic [MAG_W-1:0]   pos4;
  logic [MAG_W-1:0]   prin_ext;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [MZH_W-1:0]   mag_zhi;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic [MUL_P_W:0]   rnd_sum;
  logic [AHI_W:0]     ahi_sum;
  logic [Q_W-1:0]     q_sum;
  logic [COORD_W-1:0] sat_val;

  // End of row and end of frame tests.
  assign last_col = (CMP_W'(col_q) + CMP_W'(1) >= CMP_W'(cfg_i.image_width)) ||
                    (col_q >= COL_W'(MAX_WIDTH - 1));
  assign last_row = (CMP_W'(row_q) + CMP_W'(1) >= CMP_W'(cfg_i.image_height)) ||
                    (row_q >= ROW_W'(MAX_HEIGHT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_in) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Color packing; mono input repeats the grey byte.
  assign color_in = (cfg_i.color_mode == CMODE_MONO8) ? {red_i, red_i, red_i}
                                                      : {red_i, green_i, blue_i};

  // Signed offset of the pixel from the principal point, as sign and magnitude.
  assign pos_sel  = cmd_i.axis_y ? pos_y_q : pos_x_q;
  assign prin_sel = cmd_i.axis_y ? cfg_i.principal_y : cfg_i.principal_x;
  assign inv_sel  = cmd_i.axis_y ? cfg_i.inv_focal_y : cfg_i.inv_focal_x;
  assign pos4     = MAG_W'({pos_sel, 4'b0000});
  assign prin_ext = MAG_W'(prin_sel);
  assign neg      = pos4 < prin_ext;
  assign mag      = neg ? (prin_ext - pos4) : (pos4 - prin_ext);

  // The top two bits of z times the magnitude, by shift and add.
  assign mag_zhi = (z_q[Z_W-1] ? {1'b0, mag, 1'b0} : MZH_W'(0)) +
                   (z_q[Z_W-2] ? MZH_W'(mag) : MZH_W'(0));

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      MUL_Z: begin
        mul_a = MUL_A_W'(depth_q);
        mul_b = MUL_B_W'(cfg_i.depth_scale);
      end
      MUL_MAG_LO: begin
        mul_a = z_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(mag);
      end
      MUL_A_LO: begin
        mul_a = t_q[MUL_A_W-1:0];
        mul_b = inv_sel;
      end
      MUL_A_HI: begin
        mul_a = MUL_A_W'(ahi_q);
        mul_b = inv_sel;
      end
      default: ;
    endcase
  end

  assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Round to nearest, halves away from zero on the magnitude.
  assign rnd_sum = {1'b0, plo_q} + (MUL_P_W + 1)'(1 << (RND_SHIFT - 1));
  assign ahi_sum = {1'b0, t_q[MUL_P_W-1:MUL_A_W]} + (AHI_W + 1)'(mag_zhi);
  assign q_sum   = Q_W'({phi_q, 4'b0000}) + Q_W'(rnd_q);

  // Saturate to the signed coordinate range and apply the sign.
  always_comb begin
    if (neg_q) begin
      sat_val = (q_q >= Q_W'(NEG_LIMIT)) ? NEG_LIMIT : (COORD_W'(0) - q_q[COORD_W-1:0]);
    end else begin
      sat_val = (q_q > Q_W'(POS_LIMIT)) ? POS_LIMIT : q_q[COORD_W-1:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pos_x_q  <= POS_W'(col_q);
      pos_y_q  <= POS_W'(row_q);
      depth_q  <= depth_raw_i;
      dvalid_q <= depth_valid_i;
      color_q  <= color_in;
      fend_q   <= last_col && last_row;
    end
    case (cmd_i.mul_op)
      MUL_Z: z_q <= prod[Z_W-1:0];
      MUL_MAG_LO: begin
        t_q   <= prod;
        neg_q <= neg;
      end
      MUL_A_LO: begin
        plo_q <= prod;
        ahi_q <= ahi_sum[AHI_W-1:0];
      end
      MUL_A_HI: phi_q <= prod;
      default: ;
    endcase
    if (cmd_i.rnd_en) begin
      rnd_q <= rnd_sum[MUL_P_W:RND_SHIFT];
    end
    if (cmd_i.q_en) begin
      q_q <= q_sum;
    end
    if (cmd_i.res_en) begin
      if (cmd_i.axis_y) begin
        res_y_q <= sat_val;
      end else begin
        res_x_q <= sat_val;
      end
    end
    if (cmd_i.out_load) begin
      point_x_o      <= dvalid_q ? res_x_q : COORD_W'(0);
      point_y_o      <= dvalid_q ? res_y_q : COORD_W'(0);
      point_z_o      <= dvalid_q ? z_q : Z_W'(0);
      point_valid_o  <= dvalid_q;
      packed_color_o <= color_q;
      frame_end_o    <= fend_q;
    end
  end

endmodule

`default_nettype wire

FILE: design/depth_pixel_to_colored_point.sv
// ----------------------------------------------------------------------------
// Depth pixel to colored point
// Pinhole back-projection of raster-order depth pixels into colored points.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_i takes one depth word per pixel in raster order: raw depth, its
//   validity flag and the color bytes. point_o gives one point word per pixel
//   with x, y, z in Q.16, a valid flag, packed color and an end of frame mark.
//   Registers are written through cfg_we_i, cfg_index_i and cfg_wdata_i; the
//   user must do so only while no word is in flight, as the block does not enforce it.
//   A new pixel is taken in the cycle its predecessor moves into the output
//   register, so the block does not take a new pixel before its last one is
//   done. The pace is set by the single 32x24 multiplier, used seven times per
//   pixel, plus rounding and saturation steps for each axis.
//   While point_o is stalled the finished point waits in the output register;
//   the next pixel is accepted and computed, then held until that register
//   frees up.
//   Reset clears the column and row counters to the first pixel of a frame,
//   empties the output register and loads the default camera registers.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_to_colored_point #(
  parameter int unsigned MAX_WIDTH  = d2p_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = d2p_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [d2p_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [d2p_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  d2p_pixel_if.sink                             pixel_i,
  d2p_point_if.source                           point_o
);
  import d2p_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // Configuration registers.
  d2p_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer and handshake control.
  d2p_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pixel_i.valid),
    .in_ready_o  (pixel_i.ready),
    .out_ready_i (point_o.ready),
    .out_valid_o (point_o.valid),
    .cmd_o       (cmd)
  );

  // Counters, arithmetic and output register.
  d2p_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .depth_raw_i    (pixel_i.depth_raw),
    .depth_valid_i  (pixel_i.depth_valid),
    .red_i          (pixel_i.red),
    .green_i        (pixel_i.green),
    .blue_i         (pixel_i.blue),
    .point_x_o      (point_o.point_x),
    .point_y_o      (point_o.point_y),
    .point_z_o      (point_o.point_z),
    .point_valid_o  (point_o.point_valid),
    .packed_color_o (point_o.packed_color),
    .frame_end_o    (point_o.frame_end)
  );

endmodule

`default_nettype wire
